/* design/npc_pkg.sv */
// Package: shared constants, types and helpers of the non-overlapping pattern counter.
package npc_pkg;

  // Window depth, longest pattern that can ever match
  localparam int MAX_PATTERN = 32;
  // Configuration registers that hold the pattern bytes, eight bytes each
  localparam int PAT_REGS    = 4;
  localparam int PAT_BYTES   = PAT_REGS * 8;
  localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
  localparam int LEN_W       = 6;
  localparam int TOTAL_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [LEN_W-1:0]   FREE_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31   = 3'd4;

  typedef logic [PAT_BYTES-1:0][7:0]   pat_t;
  typedef logic [MAX_PATTERN-1:0][7:0] win_t;

  // Settings seen by the matcher
  typedef struct packed {
    logic [LEN_W-1:0] len;
    pat_t             pattern;
  } npc_cfg_t;

  // Pattern byte by index; bytes past the stored ones read as zero
  function automatic logic [7:0] pat_byte(pat_t p, logic [LEN_W-1:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (i < LEN_W'(PAT_BYTES)) begin
      b = p[i[PAT_IDX_W-1:0]];
    end
    return b;
  endfunction

endpackage

/* design/npc_if.sv */
// Interfaces: text byte channel and result channel of the pattern counter.
interface npc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface npc_out_if;
  logic        valid;
  logic        ready;
  logic        match_ends_here;
  logic [15:0] occurrences;
  logic        text_done;

  modport source (output valid, output match_ends_here, output occurrences,
                  output text_done, input ready);
  modport sink   (input valid, input match_ends_here, input occurrences,
                  input text_done, output ready);
endinterface

/* design/npc_cfg.sv */
// Configuration registers: pattern length and packed pattern bytes.
module npc_cfg
  import npc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output npc_cfg_t              cfg
);

  logic [LEN_W-1:0] len_r, len_nxt;
  pat_t             pat_r, pat_nxt;

  // Decode of a register write; unknown indexes are dropped
  always_comb begin
    len_nxt = len_r;
    pat_nxt = pat_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LEN: len_nxt = cfg_data[LEN_W-1:0];
        CFG_PAT_0_7: begin
          for (int b = 0; b < 8; b++) pat_nxt[b] = cfg_data[8*b +: 8];
        end
        CFG_PAT_8_15: begin
          for (int b = 0; b < 8; b++) pat_nxt[8 + b] = cfg_data[8*b +: 8];
        end
        CFG_PAT_16_23: begin
          for (int b = 0; b < 8; b++) pat_nxt[16 + b] = cfg_data[8*b +: 8];
        end
        CFG_PAT_24_31: begin
          for (int b = 0; b < 8; b++) pat_nxt[24 + b] = cfg_data[8*b +: 8];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pat_r <= '0;
    end else begin
      len_r <= len_nxt;
      pat_r <= pat_nxt;
    end
  end

  assign cfg.len     = len_r;
  assign cfg.pattern = pat_r;

endmodule

/* design/npc_match.sv */
// Parallel window compare: does the pattern end at the newest byte?
module npc_match
  import npc_pkg::*;
(
  input  npc_cfg_t         cfg,
  input  win_t             win,       // entry 0 is the newest byte
  input  logic [LEN_W-1:0] free_cnt,  // bytes since the last match ended
  output logic             hit
);

  logic             all_eq;
  logic             len_ok;
  logic [LEN_W-1:0] idx;

  // Each window entry below the length against its pattern byte
  always_comb begin
    all_eq = 1'b1;
    idx    = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = cfg.len - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) < cfg.len && win[k] != pat_byte(cfg.pattern, idx)) begin
        all_eq = 1'b0;
      end
    end
  end

  assign len_ok = (cfg.len != '0) && ({1'b0, cfg.len} <= (LEN_W+1)'(MAX_PATTERN));
  assign hit    = len_ok && (free_cnt >= cfg.len) && all_eq;

endmodule

/* design/nonoverlap_pattern_counter.sv */
// Top level: non-overlapping pattern counter over a byte stream.
//
// Text bytes arrive on in_ch, one per beat, with end_of_text on the last one.
// Every byte gives one result beat on out_ch: match_ends_here when a counted
// occurrence of the pattern ends at that byte, occurrences counted so far in
// the text (saturating at 65535) and text_done on the last byte's result.
// The user must write the pattern and its length through cfg_we/cfg_index/
// cfg_data while no text is in flight, which the block does not enforce; a
// length of zero disables matching. A byte goes first into an input register,
// then through the 32-byte parallel window compare into the result register.
// Throughput is one byte per cycle while the receiver does not stall; the
// window compare and count update are combinational between the two registers.
// When the receiver stalls, the result register holds and one more byte waits
// in the input register; in_ch.ready drops only once both are full.
// Reset clears the pattern, the length, the window and the counters. After the
// last byte of a text the window and counters clear; the pattern stays.
module nonoverlap_pattern_counter
  import npc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  npc_in_if.sink                in_ch,
  npc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  npc_cfg_t cfg;

  logic             s1_v_r, s1_v_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  logic             out_v_r, out_v_nxt;
  logic             out_hit_r;
  logic [TOTAL_W-1:0] out_cnt_r;
  logic             out_done_r;

  win_t               win_r, win_nxt, win_new;
  logic [LEN_W-1:0]   free_r, free_nxt, free_inc;
  logic [TOTAL_W-1:0] total_r, total_nxt, total_inc;
  logic               hit;
  logic               out_free, s1_go, in_take;

  npc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: result register frees up when empty or taken
  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_go       = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Window with the byte in the input register shifted in
  assign win_new  = {win_r[MAX_PATTERN-2:0], s1_byte_r};
  assign free_inc = (free_r < FREE_MAX) ? free_r + LEN_W'(1) : free_r;

  npc_match u_match (
    .cfg      (cfg),
    .win      (win_new),
    .free_cnt (free_inc),
    .hit      (hit)
  );

  assign total_inc = (hit && total_r < TOTAL_MAX) ? total_r + TOTAL_W'(1) : total_r;

  // Text state update as a byte moves into the result register
  always_comb begin
    win_nxt   = win_r;
    free_nxt  = free_r;
    total_nxt = total_r;
    if (s1_go) begin
      if (s1_last_r) begin
        win_nxt   = '0;
        free_nxt  = '0;
        total_nxt = '0;
      end else begin
        win_nxt   = win_new;
        free_nxt  = hit ? '0 : free_inc;
        total_nxt = total_inc;
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take)    s1_v_nxt = 1'b1;
    else if (s1_go) s1_v_nxt = 1'b0;
    out_v_nxt = out_free ? s1_v_r : out_v_r;
  end

  // Control and text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      win_r   <= '0;
      free_r  <= '0;
      total_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      win_r   <= win_nxt;
      free_r  <= free_nxt;
      total_r <= total_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.text_byte;
      s1_last_r <= in_ch.end_of_text;
    end
    if (s1_go) begin
      out_hit_r  <= hit;
      out_cnt_r  <= total_inc;
      out_done_r <= s1_last_r;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.match_ends_here = out_hit_r;
  assign out_ch.occurrences     = out_cnt_r;
  assign out_ch.text_done       = out_done_r;

`ifndef SYNTH
  // A counted match is always reflected in the count
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.match_ends_here |-> out_ch.occurrences != '0)
    else $error("match reported with zero count");

  // A byte waiting in the input register is never dropped
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_free |=> s1_v_r)
    else $error("stalled byte lost from input register");

  // The end of a text leaves clean counters
  a_text_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> total_r == '0 && free_r == '0)
    else $error("text state not cleared after last byte");

  // After a non-final match the next one needs a full pattern length
  a_match_frees: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && hit && !s1_last_r |=> free_r == '0)
    else $error("free count not restarted after match");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Testbench: self-checking stimulus, prediction and result checks for the pattern counter.
module tb_top;
  import npc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 1150;
  localparam int MAX_GAP    = 8;
  localparam int LONG_HOLD  = 300;
  localparam int MAX_PRINTS = 50;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic               match;
    logic [TOTAL_W-1:0] occ;
    logic               done;
  } occ_res_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [7:0]             tbyte;
    logic                   eot;
    bit                     typed;
    occ_res_t               want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  npc_in_if  in_if ();
  npc_out_if out_if ();

  nonoverlap_pattern_counter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state: window, free-byte count, running total and settings
  win_t                       window    = '0;
  logic [LEN_W-1:0]           free_cnt  = '0;
  logic [TOTAL_W-1:0]         total     = '0;
  logic [LEN_W-1:0]           pat_len   = '0;
  logic [PAT_REGS-1:0][63:0]  pat_words = '0;

  occ_res_t occ_expected[$];
  int       errors       = 0;
  int       results_seen = 0;
  int       rand_items   = 0;
  bit       no_idle      = 1'b0;

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PATTERN_LEN: pat_len      = data[LEN_W-1:0];
      CFG_PAT_0_7:     pat_words[0] = data;
      CFG_PAT_8_15:    pat_words[1] = data;
      CFG_PAT_16_23:   pat_words[2] = data;
      CFG_PAT_24_31:   pat_words[3] = data;
      default: ;
    endcase
  endfunction

  // One text byte in, one result out; text state clears after the last byte
  function automatic occ_res_t predict_occurrence(input logic [7:0] b, input logic eot);
    occ_res_t r;
    pat_t     pat;
    logic     hit;
    int       len;
    int       k;
    pat = pat_t'(pat_words);
    len = int'(pat_len);
    window = {window[MAX_PATTERN-2:0], b};
    if (free_cnt != FREE_MAX) free_cnt = free_cnt + 1'b1;
    hit = (len != 0) && (len <= MAX_PATTERN) && (int'(free_cnt) >= len);
    for (k = 0; k < len && hit; k++) begin
      if (window[k] != pat[len-1-k]) hit = 1'b0;
    end
    if (hit) begin
      if (total != TOTAL_MAX) total = total + 1'b1;
      free_cnt = '0;
    end
    r.match = hit;
    r.occ   = total;
    r.done  = eot;
    if (eot) begin
      window   = '0;
      free_cnt = '0;
      total    = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Directed table builders
  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{ROW_CFG, idx, data, 8'h00, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] b, input logic eot);
    dir_row_t r;
    r = '{ROW_BYTE, CFG_PATTERN_LEN, '0, b, eot, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [7:0] b, input logic eot,
                                         input logic m, input logic [TOTAL_W-1:0] occ);
    dir_row_t r;
    r = '{ROW_BYTE, CFG_PATTERN_LEN, '0, b, eot, 1'b1, '{m, occ, eot}};
    return r;
  endfunction

  // Sender: called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] b, input logic eot, input int gap,
                           input bit typed, input occ_res_t want);
    occ_res_t got;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (!in_if.ready);
    got = predict_occurrence(b, eot);
    occ_expected.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drain: stop offering, wait for every result, then let the pipe settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (occ_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Compare one result beat with the oldest expectation
  task automatic check_result();
    occ_res_t want;
    results_seen++;
    if (occ_expected.size() == 0) begin
      flag_mismatch("result beat with nothing outstanding");
      return;
    end
    want = occ_expected.pop_front();
    if (out_if.match_ends_here !== want.match)
      flag_mismatch($sformatf("match_ends_here got %b want %b", out_if.match_ends_here,
                              want.match));
    if (out_if.occurrences !== want.occ)
      flag_mismatch($sformatf("occurrences got %0d want %0d", out_if.occurrences, want.occ));
    if (out_if.text_done !== want.done)
      flag_mismatch($sformatf("text_done got %b want %b", out_if.text_done, want.done));
  endtask

  // Result sink with random stalls and two long hold-offs
  initial begin : result_sink
    int w;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (results_seen == 400 || results_seen == 900) w = LONG_HOLD;
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      check_result();
      @(negedge clk);
    end
  end

  // Main stimulus
  initial begin : stimulus
    dir_row_t                  dir_rows[$];
    logic [7:0]                txt[$];
    logic [PAT_REGS-1:0][63:0] words;
    pat_t                      p;
    logic [7:0]                a0, a1, cb;
    int                        len, plen, sel, tlen, ntext, pos, k, t;

    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.text_byte   = 8'h00;
    in_if.end_of_text = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PATTERN_LEN;
    cfg_data          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    dir_rows = '{
      // after reset the length is zero: nothing matches
      typed_row(8'h00, 1'b0, 1'b0, 16'd0),
      typed_row(8'hFF, 1'b1, 1'b0, 16'd0),
      // single zero byte as pattern; upper length bits are dropped
      cfg_row(CFG_PAT_0_7, 64'h0),
      cfg_row(CFG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFC1),
      typed_row(8'h00, 1'b0, 1'b1, 16'd1),
      typed_row(8'h00, 1'b0, 1'b1, 16'd2),
      typed_row(8'hFF, 1'b0, 1'b0, 16'd2),
      typed_row(8'h00, 1'b1, 1'b1, 16'd3),
      // "aa" over "aaaaa": overlapping hits are skipped
      cfg_row(CFG_PAT_0_7, 64'hFFFF_FFFF_FFFF_6161),
      cfg_row(CFG_PATTERN_LEN, 64'd2),
      typed_row(8'h61, 1'b0, 1'b0, 16'd0),
      typed_row(8'h61, 1'b0, 1'b1, 16'd1),
      typed_row(8'h61, 1'b0, 1'b0, 16'd1),
      typed_row(8'h61, 1'b0, 1'b1, 16'd2),
      typed_row(8'h61, 1'b1, 1'b0, 16'd2),
      // fill the rest with ones; stray indexes must not touch the pattern
      cfg_row(CFG_PAT_8_15, '1),
      cfg_row(CFG_PAT_16_23, '1),
      cfg_row(CFG_PAT_24_31, '1),
      cfg_row(CFG_UNUSED_5, '1),
      cfg_row(CFG_UNUSED_7, '1),
      typed_row(8'h61, 1'b0, 1'b0, 16'd0),
      typed_row(8'h61, 1'b1, 1'b1, 16'd1),
      // lengths past the window never match
      cfg_row(CFG_PATTERN_LEN, 64'd33),
      typed_row(8'h61, 1'b0, 1'b0, 16'd0),
      typed_row(8'hFF, 1'b1, 1'b0, 16'd0),
      cfg_row(CFG_PATTERN_LEN, 64'd63),
      typed_row(8'hFF, 1'b1, 1'b0, 16'd0),
      // full-length pattern, predictor only
      cfg_row(CFG_PATTERN_LEN, 64'd32),
      byte_row(8'h80, 1'b0),
      byte_row(8'h7F, 1'b0),
      byte_row(8'h61, 1'b1)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_byte(dir_rows[i].tbyte, dir_rows[i].eot, $urandom_range(0, MAX_GAP),
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: new settings, then a few texts built around the pattern
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      no_idle = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 9);
      case (sel)
        0:       len = 0;
        1:       len = 1;
        2, 3, 4: len = $urandom_range(2, 6);
        5, 6:    len = $urandom_range(7, 31);
        7, 8:    len = MAX_PATTERN;
        default: len = $urandom_range(MAX_PATTERN + 1, 63);
      endcase
      a0 = 8'($urandom_range(0, 255));
      a1 = ($urandom_range(0, 1) == 0) ? (a0 ^ (8'h01 << $urandom_range(0, 7)))
                                       : 8'($urandom_range(0, 255));
      for (k = 0; k < PAT_BYTES; k++) begin
        if (k < len) p[k] = $urandom_range(0, 1) ? a1 : a0;
        else         p[k] = 8'($urandom_range(0, 255));
      end
      words = (PAT_REGS*64)'(p);
      write_reg(CFG_PAT_0_7,   words[0]);
      write_reg(CFG_PAT_8_15,  words[1]);
      write_reg(CFG_PAT_16_23, words[2]);
      write_reg(CFG_PAT_24_31, words[3]);
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_5 : CFG_UNUSED_7, {$urandom, $urandom});
      write_reg(CFG_PATTERN_LEN, {$urandom, 26'($urandom), 6'(len)});

      plen  = (len > MAX_PATTERN) ? MAX_PATTERN : len;
      ntext = $urandom_range(1, 3);
      for (t = 0; t < ntext; t++) begin
        tlen = (plen >= 7) ? $urandom_range(plen, 3 * plen + 10) : $urandom_range(1, 40);
        txt.delete();
        while (txt.size() < tlen) begin
          sel = $urandom_range(0, 9);
          if (sel <= 4 && plen > 0) begin
            // pattern copy, now and then with one byte spoilt
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plen - 1) : -1;
            for (k = 0; k < plen && txt.size() < tlen; k++) begin
              cb = p[k];
              if (k == pos) cb = cb ^ (8'h01 << $urandom_range(0, 7));
              txt.push_back(cb);
            end
          end else if (sel <= 8) begin
            txt.push_back($urandom_range(0, 1) ? a1 : a0);
          end else begin
            txt.push_back(8'($urandom_range(0, 255)));
          end
        end
        foreach (txt[j]) begin
          send_byte(txt[j], j == txt.size() - 1, draw_gap(), 1'b0, '0);
          rand_items++;
        end
      end
    end

    wait_idle();
    no_idle = 1'b0;

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
